// ===== src/lzwd_pkg.sv =====
// Shared types, constants and helpers for the LZ window decompressor.
// Used by the packer, the top level and the port checker; depends on nothing.
package lzwd_pkg;

	// History window (fixed 4 KiB) and its address width
	localparam int WINDOW_DEPTH = 4096;
	localparam int WIN_AW       = $clog2(WINDOW_DEPTH);

	// Result lanes
	localparam int LANES_MAX     = 8;
	localparam int OUT_LANES_DEF = 8;
	localparam int CNT_W         = 4;
	localparam int LANE_IW       = 3;

	// Stream format
	localparam int          SIZE_W        = 32;
	localparam int          LEN_W         = 9;
	localparam logic [4:0]  HDR_LEN       = 5'd16;
	localparam logic [4:0]  HDR_MAGIC_END = 5'd4;
	localparam logic [4:0]  HDR_SIZE_END  = 5'd8;
	localparam logic [4:0]  HDR_LAST      = 5'd15;
	localparam logic [8:0]  LONG_BIAS     = 9'h012;
	localparam logic [8:0]  SHORT_BIAS    = 9'd2;
	localparam logic [3:0]  GROUP_FLAGS   = 4'd8;

	// Error codes reported on the last result of a transaction
	localparam logic [2:0] ERR_OK      = 3'd0;
	localparam logic [2:0] ERR_MAGIC   = 3'd1;
	localparam logic [2:0] ERR_FAR     = 3'd2;
	localparam logic [2:0] ERR_TRUNC   = 3'd3;
	localparam logic [2:0] ERR_OVERRUN = 3'd4;

	// Flags attached to the closing result of one input byte
	typedef struct packed {
		logic       run_end;
		logic [2:0] err;
	} fin_t;

	// Packer status seen by the sequencer
	typedef struct packed {
		logic put_ok;
		logic fin_ok;
	} pack_st_t;

	// Expected magic byte at header position 0..3
	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0: b = 8'h59;
			2'd1: b = 8'h61;
			2'd2: b = 8'h7a;
			default: b = 8'h30;
		endcase
		return b;
	endfunction

endpackage

// ===== src/lzwd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the history window of the decompressor.
module lzwd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read, held while idle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/lzwd_packer.sv =====
// Packs produced bytes into lanes and holds the output result register.
// Depends on lzwd_pkg.
module lzwd_packer import lzwd_pkg::*; #(
	parameter int OUT_LANES = OUT_LANES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          put_en,
	input  logic [7:0]                    put_data,
	input  logic                          fin_en,
	input  fin_t                          fin_info,
	output pack_st_t                      pk_st,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [LANES_MAX-1:0][7:0]     out_bytes,
	output logic [CNT_W-1:0]              out_count,
	output logic                          out_last,
	output logic                          out_end,
	output logic [2:0]                    out_err
);

	logic [LANES_MAX-1:0][7:0] lanes_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      out_valid_q;
	logic [LANES_MAX-1:0][7:0] out_bytes_q;
	logic [CNT_W-1:0]          out_count_q;
	logic                      out_last_q;
	logic                      out_end_q;
	logic [2:0]                out_err_q;

	logic                      out_free;
	logic                      lane_full;
	logic                      fin_need;
	logic                      load;
	logic [LANES_MAX-1:0][7:0] emit_bytes;

	assign out_free  = !out_valid_q || out_ready;
	assign lane_full = (cnt_q == CNT_W'(OUT_LANES));
	assign fin_need  = (cnt_q != '0) || fin_info.run_end || (fin_info.err != ERR_OK);
	assign load      = (put_en && lane_full) || (fin_en && fin_need);

	assign pk_st.put_ok = !lane_full || out_free;
	assign pk_st.fin_ok = out_free;

	// Zero the lanes past the fill count
	always_comb begin
		for (int j = 0; j < LANES_MAX; j++) begin
			emit_bytes[j] = (CNT_W'(j) < cnt_q) ? lanes_q[j] : 8'd0;
		end
	end

	// Advance the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (put_en) begin
			cnt_q <= lane_full ? CNT_W'(1) : cnt_q + CNT_W'(1);
		end else if (fin_en) begin
			cnt_q <= '0;
		end
	end

	// Lane data
	always_ff @(posedge clk) begin
		if (put_en) begin
			if (lane_full) begin
				lanes_q[0] <= put_data;
			end else begin
				lanes_q[cnt_q[LANE_IW-1:0]] <= put_data;
			end
		end
	end

	// Output register valid: load a result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_bytes_q <= emit_bytes;
			out_count_q <= cnt_q;
			out_last_q  <= fin_en;
			out_end_q   <= fin_en && fin_info.run_end;
			out_err_q   <= fin_en ? fin_info.err : ERR_OK;
		end
	end

	assign out_valid = out_valid_q;
	assign out_bytes = out_bytes_q;
	assign out_count = out_count_q;
	assign out_last  = out_last_q;
	assign out_end   = out_end_q;
	assign out_err   = out_err_q;

endmodule

// ===== src/lz_window_decompressor.sv =====
// Top level of the LZ window decompressor: stream decoder and byte sequencer.
// Depends on lzwd_pkg, lzwd_ram and lzwd_packer.
//
// Usage:
//  - Input channel (in_valid/in_ready, in_byte, in_last) takes one compressed byte
//    per transaction: a 16-byte header (magic, big-endian size, 8 spare bytes),
//    then group bytes, literals and 2- or 3-byte back-references.
//  - Output channel (out_valid/out_ready) returns results of up to OUT_LANES bytes;
//    run_last marks the last result of one input byte, which also carries
//    stream_end and error_code. A byte with nothing to report gives no result.
//  - Timing: in_ready is high only while the sequencer is idle. A byte that
//    completes no back-reference goes from ST_IDLE through ST_FINISH; one that
//    does first passes ST_COPY_RD and ST_COPY_WR once per copied byte, as the
//    single history RAM alternates a read and a write. A literal's result is
//    loaded into the output register from ST_FINISH once that register is free.
//  - A stalled receiver holds the output register; the sequencer then waits
//    whenever a full lane group or a closing result has nowhere to go.
//  - Reset clears all decoder state; the history RAM needs no clearing pass as
//    no entry is read before it is written. in_last returns the decoder to
//    the start of a header once the byte has been handled.
module lz_window_decompressor import lzwd_pkg::*; #(
	parameter int OUT_LANES = OUT_LANES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       in_byte,
	input  logic             in_last,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       byte_0,
	output logic [7:0]       byte_1,
	output logic [7:0]       byte_2,
	output logic [7:0]       byte_3,
	output logic [7:0]       byte_4,
	output logic [7:0]       byte_5,
	output logic [7:0]       byte_6,
	output logic [7:0]       byte_7,
	output logic [CNT_W-1:0] byte_count,
	output logic             run_last,
	output logic             stream_end,
	output logic [2:0]       error_code
);

	typedef enum logic [3:0] {
		ST_IDLE    = 4'b0001,
		ST_COPY_RD = 4'b0010,
		ST_COPY_WR = 4'b0100,
		ST_FINISH  = 4'b1000
	} state_t;

	typedef enum logic [3:0] {
		PH_GROUP = 4'b0001,
		PH_START = 4'b0010,
		PH_REF2  = 4'b0100,
		PH_LEN   = 4'b1000
	} phase_t;

	state_t            state_q, state_d;
	phase_t            phase_q, phase_d;
	logic [4:0]        hdr_q, hdr_d;
	logic [SIZE_W-1:0] rem_q, rem_d;
	logic [SIZE_W-1:0] bw_q, bw_d;
	logic [7:0]        flags_q, flags_d;
	logic [3:0]        left_q, left_d;
	logic [15:0]       token_q, token_d;
	logic              disc_q, disc_d;
	logic [2:0]        err_q, err_d;
	logic              run_end_q, run_end_d;
	logic              last_q, last_d;
	logic [LEN_W-1:0]  cleft_q, cleft_d;

	logic              put_en;
	logic [7:0]        put_data;
	logic              fin_en;
	fin_t              fin_info;
	pack_st_t          pk_st;
	logic              rd_en;
	logic [WIN_AW-1:0] rd_addr;
	logic [7:0]        rd_data;
	logic [3:0]        left_dec;
	logic [11:0]       copy_tok12;
	logic [LEN_W-1:0]  copy_len;
	logic              copy_far;
	logic              copy_over;
	logic [LANES_MAX-1:0][7:0] out_bytes;

	assign in_ready = (state_q == ST_IDLE);

	// Back-reference checks, valid in the token phases that close a reference
	assign copy_tok12 = (phase_q == PH_LEN) ? token_q[11:0] : {token_q[11:8], in_byte};
	assign copy_len   = (phase_q == PH_LEN) ? ({1'b0, in_byte} + LONG_BIAS)
	                                        : ({5'd0, token_q[15:12]} + SHORT_BIAS);
	assign copy_far   = (bw_q[SIZE_W-1:WIN_AW] == '0) && (copy_tok12 >= bw_q[WIN_AW-1:0]);
	assign copy_over  = (rem_q[SIZE_W-1:LEN_W] == '0) && (copy_len > rem_q[LEN_W-1:0]);
	assign left_dec   = (left_q != 4'd0) ? left_q - 4'd1 : 4'd0;

	// Copy source: current write position minus distance
	assign rd_addr = bw_q[WIN_AW-1:0] - token_q[11:0] - WIN_AW'(1);

	assign fin_info.run_end = run_end_q;
	assign fin_info.err     = (last_q && !disc_q) ? ERR_TRUNC : err_q;

	// Sequencer and stream decoder
	always_comb begin
		state_d   = state_q;
		phase_d   = phase_q;
		hdr_d     = hdr_q;
		rem_d     = rem_q;
		bw_d      = bw_q;
		flags_d   = flags_q;
		left_d    = left_q;
		token_d   = token_q;
		disc_d    = disc_q;
		err_d     = err_q;
		run_end_d = run_end_q;
		last_d    = last_q;
		cleft_d   = cleft_q;
		put_en    = 1'b0;
		put_data  = in_byte;
		fin_en    = 1'b0;
		rd_en     = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					err_d     = ERR_OK;
					run_end_d = 1'b0;
					last_d    = in_last;
					state_d   = ST_FINISH;
					if (!disc_q) begin
						if (hdr_q != HDR_LEN) begin
							// Header: magic check, then size bytes
							if (hdr_q < HDR_MAGIC_END) begin
								if (in_byte != magic_byte(hdr_q[1:0])) begin
									err_d  = ERR_MAGIC;
									disc_d = 1'b1;
								end
							end else if (hdr_q < HDR_SIZE_END) begin
								rem_d = {rem_q[SIZE_W-9:0], in_byte};
							end
							hdr_d = hdr_q + 5'd1;
							if (hdr_q == HDR_LAST && rem_q == '0) begin
								run_end_d = 1'b1;
								disc_d    = 1'b1;
							end
						end else begin
							case (phase_q)
								PH_GROUP: begin
									flags_d = in_byte;
									left_d  = GROUP_FLAGS;
									phase_d = PH_START;
								end
								PH_START: begin
									if (flags_q[7]) begin
										put_en  = 1'b1;
										flags_d = {flags_q[6:0], 1'b0};
										left_d  = left_dec;
										phase_d = (left_dec != 4'd0) ? PH_START : PH_GROUP;
									end else begin
										token_d = {in_byte, 8'd0};
										phase_d = PH_REF2;
									end
								end
								PH_REF2, PH_LEN: begin
									if (phase_q == PH_REF2) begin
										token_d = {token_q[15:8], in_byte};
									end
									if (phase_q == PH_REF2 && token_q[15:12] == 4'd0) begin
										phase_d = PH_LEN;
									end else if (copy_far) begin
										err_d  = ERR_FAR;
										disc_d = 1'b1;
									end else if (copy_over) begin
										err_d  = ERR_OVERRUN;
										disc_d = 1'b1;
									end else begin
										cleft_d = copy_len;
										state_d = ST_COPY_RD;
										flags_d = {flags_q[6:0], 1'b0};
										left_d  = left_dec;
										phase_d = (left_dec != 4'd0) ? PH_START : PH_GROUP;
									end
								end
								default: begin
									phase_d = PH_GROUP;
								end
							endcase
						end
					end
				end
			end
			ST_COPY_RD: begin
				rd_en   = 1'b1;
				state_d = ST_COPY_WR;
			end
			ST_COPY_WR: begin
				if (pk_st.put_ok) begin
					put_en   = 1'b1;
					put_data = rd_data;
					cleft_d  = cleft_q - LEN_W'(1);
					state_d  = (cleft_q == LEN_W'(1)) ? ST_FINISH : ST_COPY_RD;
				end
			end
			ST_FINISH: begin
				if (pk_st.fin_ok) begin
					fin_en  = 1'b1;
					state_d = ST_IDLE;
					if (last_q) begin
						hdr_d   = '0;
						rem_d   = '0;
						bw_d    = '0;
						flags_d = '0;
						left_d  = '0;
						phase_d = PH_GROUP;
						token_d = '0;
						disc_d  = 1'b0;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// Shared byte writer: advance position and count down the bytes due
		if (put_en) begin
			bw_d  = bw_q + SIZE_W'(1);
			rem_d = rem_q - SIZE_W'(1);
			if (rem_q == SIZE_W'(1)) begin
				run_end_d = 1'b1;
				disc_d    = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= PH_GROUP;
			hdr_q     <= '0;
			rem_q     <= '0;
			bw_q      <= '0;
			flags_q   <= '0;
			left_q    <= '0;
			token_q   <= '0;
			disc_q    <= 1'b0;
			err_q     <= ERR_OK;
			run_end_q <= 1'b0;
			last_q    <= 1'b0;
			cleft_q   <= '0;
		end else begin
			state_q   <= state_d;
			phase_q   <= phase_d;
			hdr_q     <= hdr_d;
			rem_q     <= rem_d;
			bw_q      <= bw_d;
			flags_q   <= flags_d;
			left_q    <= left_d;
			token_q   <= token_d;
			disc_q    <= disc_d;
			err_q     <= err_d;
			run_end_q <= run_end_d;
			last_q    <= last_d;
			cleft_q   <= cleft_d;
		end
	end

	// History window
	lzwd_ram #(
		.WIDTH (8),
		.DEPTH (WINDOW_DEPTH)
	) u_hist (
		.clk     (clk),
		.wr_en   (put_en),
		.wr_addr (bw_q[WIN_AW-1:0]),
		.wr_data (put_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Lane packing and output register
	lzwd_packer #(
		.OUT_LANES (OUT_LANES)
	) u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.put_en    (put_en),
		.put_data  (put_data),
		.fin_en    (fin_en),
		.fin_info  (fin_info),
		.pk_st     (pk_st),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_bytes (out_bytes),
		.out_count (byte_count),
		.out_last  (run_last),
		.out_end   (stream_end),
		.out_err   (error_code)
	);

	assign byte_0 = out_bytes[0];
	assign byte_1 = out_bytes[1];
	assign byte_2 = out_bytes[2];
	assign byte_3 = out_bytes[3];
	assign byte_4 = out_bytes[4];
	assign byte_5 = out_bytes[5];
	assign byte_6 = out_bytes[6];
	assign byte_7 = out_bytes[7];

endmodule

// ===== src/lzwd_checker.sv =====
// Port-level checks for the LZ window decompressor, bound to the top level.
// Depends on lzwd_pkg and lz_window_decompressor.
module lzwd_checker import lzwd_pkg::*; #(
	parameter int OUT_LANES = OUT_LANES_DEF
) (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic [7:0]       in_byte,
	input logic             in_last,
	input logic             out_valid,
	input logic             out_ready,
	input logic [7:0]       byte_0,
	input logic [CNT_W-1:0] byte_count,
	input logic             run_last,
	input logic             stream_end,
	input logic [2:0]       error_code
);

	// Hold an offered transaction until it is taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_byte) && $stable(in_last))
		else $error("offered transaction changed");

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(byte_count) && $stable(byte_0)
			&& $stable(error_code) && $stable(run_last))
		else $error("stalled result changed");

	// Only full lane groups precede the closing result, and they carry no event
	a_mid_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_last |-> byte_count == CNT_W'(OUT_LANES) && !stream_end
			&& error_code == ERR_OK)
		else $error("intermediate result malformed");

	// An empty result exists only to report an event
	a_empty_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_count == '0 |-> run_last && (stream_end || error_code != ERR_OK))
		else $error("empty result without event");

	// No new transaction while a byte is still producing results
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_last |-> !in_ready)
		else $error("input taken mid-run");

endmodule

bind lz_window_decompressor lzwd_checker #(.OUT_LANES(OUT_LANES)) u_lzwd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.in_byte    (in_byte),
	.in_last    (in_last),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.byte_0     (byte_0),
	.byte_count (byte_count),
	.run_last   (run_last),
	.stream_end (stream_end),
	.error_code (error_code)
);

// ===== dv/tb_lz_window_decompressor.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for lz_window_decompressor: directed and random compressed streams.
// Depends on lzwd_pkg and the lz_window_decompressor RTL with its submodules.
module tb_lz_window_decompressor;
	import lzwd_pkg::*;

	localparam int          LANES       = OUT_LANES_DEF;
	localparam int          ITEM_TARGET = 400;
	localparam int          IDLE_LIMIT  = 20000;
	localparam logic [31:0] YAZ_SIG     = "Yaz0";

	// Decoder position within the token stream
	typedef enum logic [1:0] {
		PH_GROUP,
		PH_TOKEN,
		PH_DIST,
		PH_LEN
	} tok_phase_t;

	// One result as seen on the output channel
	typedef struct packed {
		logic [7:0][7:0] lanes;
		logic [3:0]      count;
		logic            run_last;
		logic            stream_end;
		logic [2:0]      err;
	} lz_result_t;

	// Predict decompressed output per input byte and check it against the block
	class lz_scoreboard;
		logic [7:0]  hist [WINDOW_DEPTH];
		int unsigned hdr_pos;
		logic [31:0] size_decl;
		logic [31:0] written;
		logic [7:0]  flags;
		int unsigned flags_rem;
		tok_phase_t  phase;
		logic [15:0] token;
		bit          dropping;
		bit          size_hit;
		logic [7:0]  run_q [$];
		lz_result_t  expected_q [$];
		int unsigned fails;

		function new();
			fails = 0;
			clear_stream();
		endfunction

		function void clear_stream();
			hdr_pos   = 0;
			size_decl = '0;
			written   = '0;
			flags     = '0;
			flags_rem = 0;
			phase     = PH_GROUP;
			token     = '0;
			dropping  = 1'b0;
		endfunction

		function void put_byte(logic [7:0] v);
			hist[written[11:0]] = v;
			run_q.insert(run_q.size(), v);
			written = written + 32'd1;
			if (written == size_decl) begin
				size_hit = 1'b1;
				dropping = 1'b1;
			end
		endfunction

		function void token_done();
			flags = flags << 1;
			if (flags_rem > 0)
				flags_rem--;
			phase = (flags_rem != 0) ? PH_TOKEN : PH_GROUP;
		endfunction

		// Copy len bytes from span back in the window, or flag why it cannot be done
		function logic [2:0] copy_back(int unsigned len);
			logic [31:0] span;
			logic [11:0] src;
			span = {20'd0, token[11:0]} + 32'd1;
			if (span > written) begin
				dropping = 1'b1;
				return ERR_FAR;
			end
			if (len > size_decl - written) begin
				dropping = 1'b1;
				return ERR_OVERRUN;
			end
			for (int i = 0; i < len; i++) begin
				src = written[11:0] - span[11:0];
				put_byte(hist[src]);
			end
			token_done();
			return ERR_OK;
		endfunction

		// Advance the decoder by one accepted byte and queue the results it causes
		function void note_byte(logic [7:0] b, logic last);
			logic [2:0]  err;
			int unsigned nres;
			int unsigned cnt;
			lz_result_t  r;
			err = ERR_OK;
			run_q.delete();
			size_hit = 1'b0;
			if (!dropping) begin
				if (hdr_pos < 16) begin
					if (hdr_pos < 4) begin
						if (b != YAZ_SIG[8*(3-hdr_pos) +: 8]) begin
							err = ERR_MAGIC;
							dropping = 1'b1;
						end
					end else if (hdr_pos < 8) begin
						size_decl = {size_decl[23:0], b};
					end
					hdr_pos++;
					if (!dropping && hdr_pos == 16 && size_decl == 0) begin
						size_hit = 1'b1;
						dropping = 1'b1;
					end
				end else begin
					case (phase)
						PH_GROUP: begin
							flags     = b;
							flags_rem = 8;
							phase     = PH_TOKEN;
						end
						PH_TOKEN: begin
							if (flags[7]) begin
								put_byte(b);
								token_done();
							end else begin
								token = {b, 8'h00};
								phase = PH_DIST;
							end
						end
						PH_DIST: begin
							token[7:0] = b;
							if (token[15:12] != 4'd0)
								err = copy_back(token[15:12] + 2);
							else
								phase = PH_LEN;
						end
						default: begin
							err = copy_back(b + 18);
						end
					endcase
				end
			end
			// a stream cut short while still live is truncated
			if (last) begin
				if (!dropping)
					err = ERR_TRUNC;
				clear_stream();
			end
			nres = (run_q.size() + LANES - 1) / LANES;
			if (nres == 0 && (size_hit || err != ERR_OK))
				nres = 1;
			for (int k = 0; k < nres; k++) begin
				r = '0;
				cnt = 0;
				for (int j = 0; j < LANES; j++) begin
					if (k * LANES + j < run_q.size()) begin
						r.lanes[j] = run_q[k * LANES + j];
						cnt++;
					end
				end
				r.count = 4'(cnt);
				if (k == nres - 1) begin
					r.run_last   = 1'b1;
					r.stream_end = size_hit;
					r.err        = err;
				end
				expected_q.insert(expected_q.size(), r);
			end
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected 'h%0h, got 'h%0h", name, want, got);
				fails++;
			end
		endfunction

		function void check_result(lz_result_t got);
			lz_result_t want;
			if (expected_q.size() == 0) begin
				$error("result with no transaction outstanding");
				fails++;
				return;
			end
			want = expected_q.pop_front();
			for (int j = 0; j < 8; j++)
				compare_field($sformatf("byte_%0d", j), want.lanes[j], got.lanes[j]);
			compare_field("byte_count", 8'(want.count), 8'(got.count));
			compare_field("run_last", 8'(want.run_last), 8'(got.run_last));
			compare_field("stream_end", 8'(want.stream_end), 8'(got.stream_end));
			compare_field("error_code", 8'(want.err), 8'(got.err));
		endfunction

		function int unsigned outstanding();
			return expected_q.size();
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic [7:0]       in_byte;
	logic             in_last;
	logic             out_valid;
	logic             out_ready;
	logic [7:0]       byte_0, byte_1, byte_2, byte_3;
	logic [7:0]       byte_4, byte_5, byte_6, byte_7;
	logic [CNT_W-1:0] byte_count;
	logic             run_last;
	logic             stream_end;
	logic [2:0]       error_code;

	lz_scoreboard sb;
	logic [7:0]   stream_q [$];
	int unsigned  items_sent = 0;
	int unsigned  idle_cycles = 0;
	bit           calm = 1'b0;

	lz_window_decompressor #(
		.OUT_LANES(LANES)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.byte_0     (byte_0),
		.byte_1     (byte_1),
		.byte_2     (byte_2),
		.byte_3     (byte_3),
		.byte_4     (byte_4),
		.byte_5     (byte_5),
		.byte_6     (byte_6),
		.byte_7     (byte_7),
		.byte_count (byte_count),
		.run_last   (run_last),
		.stream_end (stream_end),
		.error_code (error_code)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Offer one byte at a falling edge, hold it until the transaction completes
	task automatic send_byte(input logic [7:0] b, input logic last);
		int unsigned gap;
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid = 1'b0;
			gap = $urandom_range(1, 18);
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		in_byte  = b;
		in_last  = last;
		do @(posedge clk); while (!in_ready);
		sb.note_byte(b, last);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_stream();
		foreach (stream_q[i])
			send_byte(stream_q[i], i == stream_q.size() - 1);
	endtask

	// Build one stream: mostly well-formed with random content, some broken or noise
	task automatic gen_stream();
		int unsigned mode, size_sel, cap, made, remain, len, back, upper, idx;
		logic [31:0] dsize;
		logic [7:0]  grp;
		logic [11:0] d1;
		logic [7:0]  body [$];
		bit          broken;
		stream_q.delete();
		mode = $urandom_range(0, 19);
		if (mode == 0) begin
			repeat ($urandom_range(1, 20))
				stream_q.insert(stream_q.size(), 8'($urandom));
			return;
		end
		for (int i = 0; i < 4; i++)
			stream_q.insert(stream_q.size(), YAZ_SIG[8*(3-i) +: 8]);
		if (mode == 1) begin
			idx = $urandom_range(0, 3);
			stream_q[idx] = stream_q[idx] ^ 8'($urandom_range(1, 255));
		end
		size_sel = $urandom_range(0, 15);
		if (size_sel <= 1)
			dsize = 32'd0;
		else if (size_sel == 2)
			dsize = $urandom;
		else if (size_sel <= 4)
			dsize = $urandom_range(200, 700);
		else
			dsize = $urandom_range(1, 32);
		for (int i = 0; i < 4; i++)
			stream_q.insert(stream_q.size(), dsize[8*(3-i) +: 8]);
		repeat (8)
			stream_q.insert(stream_q.size(), 8'($urandom));
		cap = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 24) : 160;
		made = 0;
		broken = 1'b0;
		while (made < dsize && !broken && stream_q.size() < 16 + cap) begin
			grp = 8'($urandom);
			body.delete();
			for (int f = 7; f >= 0 && made < dsize && !broken; f--) begin
				remain = dsize - made;
				if (made == 0 || remain < 3 || $urandom_range(0, 2) == 0) begin
					grp[f] = 1'b1;
					body.insert(body.size(), 8'($urandom));
					made++;
				end else begin
					grp[f] = 1'b0;
					back = $urandom_range(1, (made < 4096) ? made : 4096);
					if (remain > 17 && $urandom_range(0, 3) == 0) begin
						upper = ($urandom_range(0, 7) == 0) ? 273 : 40;
						len = $urandom_range(18, (remain < upper) ? remain : upper);
					end else begin
						len = $urandom_range(3, (remain < 17) ? remain : 17);
					end
					// now and then reach too far back or past the declared size
					if ($urandom_range(0, 39) == 0) begin
						broken = 1'b1;
						if (remain < 273 && $urandom_range(0, 1) == 1)
							len = $urandom_range(remain + 1, 273);
						else if (made < 4096)
							back = $urandom_range(made + 1, 4096);
						else
							broken = 1'b0;
					end
					d1 = 12'(back - 1);
					if (len <= 17) begin
						body.insert(body.size(), {4'(len - 2), d1[11:8]});
						body.insert(body.size(), d1[7:0]);
					end else begin
						body.insert(body.size(), {4'h0, d1[11:8]});
						body.insert(body.size(), d1[7:0]);
						body.insert(body.size(), 8'(len - 18));
					end
					if (!broken)
						made += len;
				end
			end
			stream_q.insert(stream_q.size(), grp);
			foreach (body[i])
				stream_q.insert(stream_q.size(), body[i]);
		end
		// trailing bytes to be dropped, or an early end
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 5))
				stream_q.insert(stream_q.size(), 8'($urandom));
		if (stream_q.size() > 1 && $urandom_range(0, 7) == 0)
			stream_q = stream_q[0:$urandom_range(1, stream_q.size() - 1) - 1];
	endtask

	// Check every accepted result
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result({byte_7, byte_6, byte_5, byte_4, byte_3, byte_2, byte_1, byte_0,
				byte_count, run_last, stream_end, error_code});
	end

	// End the run when no transaction completes for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Stall the receiver in bursts until the closing part of the run
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			out_ready = 1'b1;
			repeat ($urandom_range(1, 40)) @(negedge clk);
			if (!calm) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 18)) @(negedge clk);
			end
		end
	end

	initial begin
		sb       = new();
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_byte  = 8'h00;
		in_last  = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// lone wrong magic byte that also ends its stream
		stream_q = '{8'hFF};
		send_stream();
		// literals 00 and FF, short copy, longest copy, then a reference too far back
		stream_q = '{8'h59, 8'h61, 8'h7a, 8'h30, 8'h00, 8'h00, 8'h01, 8'h20,
			8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
			8'hC0, 8'h00, 8'hFF, 8'h10, 8'h00, 8'h00, 8'h01, 8'hFF,
			8'h0F, 8'hFF, 8'h5A};
		send_stream();

		while (items_sent < ITEM_TARGET) begin
			if (items_sent > ITEM_TARGET * 4 / 5)
				calm = 1'b1;
			gen_stream();
			send_stream();
		end
		calm     = 1'b1;
		in_valid = 1'b0;
		in_last  = 1'b0;

		// drain, then allow for any late result
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.fails == 0 && sb.outstanding() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/lzwd_pkg.sv
src/lzwd_ram.sv
src/lzwd_packer.sv
src/lz_window_decompressor.sv
src/lzwd_checker.sv
dv/tb_lz_window_decompressor.sv
